/* rtl/core/xsr_pkg.sv */
// Shared types, codes and helpers for the ranged xorshift random unit.
package xsr_pkg;

   localparam int unsigned DATA_W  = 64;
   localparam int unsigned SHIFT_W = 6;
   localparam int unsigned CNT_W   = 6;
   localparam int unsigned ADDR_W  = 4;
   localparam int unsigned PDATA_W = 32;

   localparam logic [DATA_W-1:0]  GEN_RESET          = 64'd1;
   localparam logic [SHIFT_W-1:0] SHIFT_FIRST_RESET  = 6'd12;
   localparam logic [SHIFT_W-1:0] SHIFT_SECOND_RESET = 6'd25;
   localparam logic [SHIFT_W-1:0] SHIFT_THIRD_RESET  = 6'd27;

   // register indexes (paddr[3:2])
   localparam logic [1:0] CSR_SHIFT_FIRST  = 2'd0;
   localparam logic [1:0] CSR_SHIFT_SECOND = 2'd1;
   localparam logic [1:0] CSR_SHIFT_THIRD  = 2'd2;

   // request codes
   localparam logic [1:0] REQ_RESEED = 2'd0;
   localparam logic [1:0] REQ_RAW    = 2'd1;
   localparam logic [1:0] REQ_RANGED = 2'd2;

   // width codes
   localparam logic [1:0] WID_64 = 2'd0;
   localparam logic [1:0] WID_32 = 2'd1;

   // advance step indexes
   localparam logic [1:0] STEP_FIRST  = 2'd0;
   localparam logic [1:0] STEP_SECOND = 2'd1;
   localparam logic [1:0] STEP_THIRD  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADV,
      ST_DIVGO,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [SHIFT_W-1:0] first;
      logic [SHIFT_W-1:0] second;
      logic [SHIFT_W-1:0] third;
   } shift_cfg_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] remainder;
   } div_stat_type;

   function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] sel);
      logic [DATA_W-1:0] m;
      case (sel)
         WID_64:  m = {DATA_W{1'b1}};
         WID_32:  m = {{(DATA_W-32){1'b0}}, {32{1'b1}}};
         default: m = {{(DATA_W-16){1'b0}}, {16{1'b1}}};
      endcase
      return m;
   endfunction

endpackage

/* rtl/core/xsr_req_if.sv */
// Request channel interface of the ranged xorshift random unit.
interface xsr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [63:0] seed_value;
   logic [1:0]  width_sel;
   logic [63:0] range_low;
   logic [63:0] range_high;

   modport source (
      output valid, req_type, seed_value, width_sel, range_low, range_high,
      input  ready
   );
   modport sink (
      input  valid, req_type, seed_value, width_sel, range_low, range_high,
      output ready
   );
endinterface

/* rtl/core/xsr_rsp_if.sv */
// Response channel interface of the ranged xorshift random unit.
interface xsr_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] random_value;
   logic        span_error;

   modport source (
      output valid, random_value, span_error,
      input  ready
   );
   modport sink (
      input  valid, random_value, span_error,
      output ready
   );
endinterface

/* rtl/core/xsr_csr.sv */
// APB register block holding the three xorshift shift amounts.
module xsr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [xsr_pkg::ADDR_W-1:0]        paddr,
   input  logic [xsr_pkg::PDATA_W-1:0]       pwdata,
   output logic [xsr_pkg::PDATA_W-1:0]       prdata,
   output logic                              pready,
   output xsr_pkg::shift_cfg_type            shift_cfg
);

   logic [xsr_pkg::SHIFT_W-1:0] first_ff, second_ff, third_ff;
   logic                        wr_en;
   logic [1:0]                  reg_idx;
   logic [xsr_pkg::SHIFT_W-1:0] rd_val;

   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= xsr_pkg::SHIFT_FIRST_RESET;
         second_ff <= xsr_pkg::SHIFT_SECOND_RESET;
         third_ff  <= xsr_pkg::SHIFT_THIRD_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            xsr_pkg::CSR_SHIFT_FIRST:  first_ff  <= pwdata[xsr_pkg::SHIFT_W-1:0];
            xsr_pkg::CSR_SHIFT_SECOND: second_ff <= pwdata[xsr_pkg::SHIFT_W-1:0];
            xsr_pkg::CSR_SHIFT_THIRD:  third_ff  <= pwdata[xsr_pkg::SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         xsr_pkg::CSR_SHIFT_FIRST:  rd_val = first_ff;
         xsr_pkg::CSR_SHIFT_SECOND: rd_val = second_ff;
         xsr_pkg::CSR_SHIFT_THIRD:  rd_val = third_ff;
         default:                   rd_val = '0;
      endcase
   end

   assign prdata = {{(xsr_pkg::PDATA_W-xsr_pkg::SHIFT_W){1'b0}}, rd_val};

   assign shift_cfg.first  = first_ff;
   assign shift_cfg.second = second_ff;
   assign shift_cfg.third  = third_ff;

endmodule

/* rtl/core/xsr_div.sv */
// Radix-2 restoring divider giving the 64-bit remainder, one bit per cycle.
module xsr_div (
   input  logic                  clock,
   input  logic                  reset,
   input  xsr_pkg::div_ctrl_type ctrl,
   output xsr_pkg::div_stat_type stat
);

   localparam int unsigned W = xsr_pkg::DATA_W;

   logic [W-1:0]                rem_ff, rem_in;
   logic [W-1:0]                dvd_ff, dvd_in;
   logic [W-1:0]                dsr_ff;
   logic [xsr_pkg::CNT_W-1:0]   cnt_ff;
   logic                        busy_ff;
   logic [W:0]                  trial;
   logic [W+1:0]                diff;

   assign trial = {rem_ff, dvd_ff[W-1]};
   assign diff  = {1'b0, trial} - {2'b00, dsr_ff};

   always_comb begin
      dvd_in = {dvd_ff[W-2:0], 1'b0};
      if (diff[W+1]) begin
         rem_in = trial[W-1:0];
      end else begin
         rem_in = diff[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (ctrl.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= {xsr_pkg::CNT_W{1'b1}};
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         rem_ff <= '0;
         dvd_ff <= ctrl.dividend;
         dsr_ff <= ctrl.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= dvd_in;
      end
   end

   // last iteration happens in this cycle; remainder is final on the next
   assign stat.done      = busy_ff & (cnt_ff == '0);
   assign stat.remainder = rem_ff;

endmodule

/* rtl/core/xorshift64_ranged_random_unit.sv */
// Top level of the ranged xorshift64 random unit: sequencer, shared shifter and result register.
//
// One request is taken at a time; ready is high only while the unit is idle and out of reset.
// A reseed or a raw draw is xor-shifted in the first, second and third steps through one
// shared barrel shifter, then its result is formed; ready returns on the next cycle. A
// ranged draw with a non-zero span is xor-shifted in the same steps, then the bit-serial
// remainder unit is started and runs to its end, and then the result is formed; a zero span
// skips the divider. A finished result sits in an output register, so a new request is
// accepted while it waits; the following result is held back until that register is free,
// and is delayed for as long as that stall lasts. Shift amounts sit in three APB registers
// at byte addresses 0, 4 and 8 and should be written only while idle.
module xorshift64_ranged_random_unit (
   input  logic                        clock,
   input  logic                        reset,
   xsr_req_if.sink                     req,
   xsr_rsp_if.source                   rsp,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [xsr_pkg::ADDR_W-1:0]  paddr,
   input  logic [xsr_pkg::PDATA_W-1:0] pwdata,
   output logic [xsr_pkg::PDATA_W-1:0] prdata,
   output logic                        pready
);

   localparam int unsigned W = xsr_pkg::DATA_W;

   xsr_pkg::shift_cfg_type shift_cfg;
   xsr_pkg::div_ctrl_type  div_ctrl;
   xsr_pkg::div_stat_type  div_stat;
   xsr_pkg::state_type     state_ff, state_in;

   logic [1:0]   step_ff;
   logic [1:0]   kind_ff;
   logic [W-1:0] gen_ff;
   logic [W-1:0] work_ff, work_in;
   logic [W-1:0] mask_ff, lo_ff, span_ff;
   logic [W-1:0] rsp_value_ff, rsp_value_in;
   logic         rsp_err_ff, rsp_err_in;
   logic         rsp_valid_ff;

   logic                        accept;
   logic                        adv_en;
   logic                        adv_last;
   logic                        fin_load;
   logic                        known_req;
   logic                        span_zero;
   logic [xsr_pkg::SHIFT_W-1:0] shamt;
   logic [W-1:0]                shifted;
   logic [W-1:0]                req_mask;
   logic [W-1:0]                ranged_sum;

   xsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .shift_cfg (shift_cfg)
   );

   xsr_div u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   assign accept    = req.valid & req.ready;
   assign known_req = (req.req_type == xsr_pkg::REQ_RESEED) ||
                      (req.req_type == xsr_pkg::REQ_RAW) ||
                      (req.req_type == xsr_pkg::REQ_RANGED);
   assign req_mask  = xsr_pkg::width_mask(req.width_sel);
   assign adv_last  = (step_ff == xsr_pkg::STEP_THIRD);
   assign span_zero = (span_ff == '0);

   // shared xor-shift unit
   always_comb begin
      case (step_ff)
         xsr_pkg::STEP_FIRST:  shamt = shift_cfg.first;
         xsr_pkg::STEP_SECOND: shamt = shift_cfg.second;
         default:              shamt = shift_cfg.third;
      endcase
      if (step_ff == xsr_pkg::STEP_SECOND) begin
         shifted = work_ff << shamt;
      end else begin
         shifted = work_ff >> shamt;
      end
      work_in = work_ff ^ shifted;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         xsr_pkg::ST_IDLE: begin
            if (req.valid) begin
               state_in = known_req ? xsr_pkg::ST_ADV : xsr_pkg::ST_FIN;
            end
         end
         xsr_pkg::ST_ADV: begin
            if (adv_last) begin
               if ((kind_ff == xsr_pkg::REQ_RANGED) && !span_zero) begin
                  state_in = xsr_pkg::ST_DIVGO;
               end else begin
                  state_in = xsr_pkg::ST_FIN;
               end
            end
         end
         xsr_pkg::ST_DIVGO: state_in = xsr_pkg::ST_DIV;
         xsr_pkg::ST_DIV: begin
            if (div_stat.done) begin
               state_in = xsr_pkg::ST_FIN;
            end
         end
         xsr_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp.ready) begin
               state_in = xsr_pkg::ST_IDLE;
            end
         end
         default: state_in = xsr_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req.ready         = 1'b0;
      adv_en            = 1'b0;
      fin_load          = 1'b0;
      div_ctrl.start    = 1'b0;
      div_ctrl.dividend = gen_ff & mask_ff;
      div_ctrl.divisor  = span_ff;
      case (state_ff)
         xsr_pkg::ST_IDLE:  req.ready      = !reset;
         xsr_pkg::ST_ADV:   adv_en         = 1'b1;
         xsr_pkg::ST_DIVGO: div_ctrl.start = 1'b1;
         xsr_pkg::ST_FIN:   fin_load       = !rsp_valid_ff || rsp.ready;
         default: ;
      endcase
   end

   assign ranged_sum = div_stat.remainder + lo_ff;

   always_comb begin
      rsp_value_in = '0;
      rsp_err_in   = 1'b0;
      case (kind_ff)
         xsr_pkg::REQ_RAW: rsp_value_in = gen_ff & mask_ff;
         xsr_pkg::REQ_RANGED: begin
            if (span_zero) begin
               rsp_value_in = lo_ff;
               rsp_err_in   = 1'b1;
            end else begin
               rsp_value_in = ranged_sum & mask_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xsr_pkg::ST_IDLE;
         step_ff      <= xsr_pkg::STEP_FIRST;
         gen_ff       <= xsr_pkg::GEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            step_ff <= xsr_pkg::STEP_FIRST;
         end else if (adv_en) begin
            step_ff <= step_ff + 1'b1;
         end
         if (adv_en && adv_last) begin
            gen_ff <= work_in;
         end
         if (fin_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req.req_type;
         mask_ff <= req_mask;
         lo_ff   <= req.range_low & req_mask;
         span_ff <= (req.range_high - req.range_low) & req_mask;
         work_ff <= (req.req_type == xsr_pkg::REQ_RESEED) ? req.seed_value : gen_ff;
      end else if (adv_en) begin
         work_ff <= work_in;
      end
      if (fin_load) begin
         rsp_value_ff <= rsp_value_in;
         rsp_err_ff   <= rsp_err_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.random_value = rsp_value_ff;
   assign rsp.span_error   = rsp_err_ff;

endmodule
